// ===== hdl/ptlru_pkg.sv =====
// Shared types and codes for the paged translation block with LRU eviction.
`timescale 1ns / 1ps

package ptlru_pkg;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_PROC  = 2'd1;
  localparam logic [1:0] STATUS_NO_VICTIM = 2'd2;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_OFFSET_BITS = 2'd0,
    REG_VPN_BITS    = 2'd1,
    REG_FRAME_COUNT = 2'd2,
    REG_PROC_COUNT  = 2'd3
  } cfg_reg_t;

  // Control from the sequencer to the age compare unit.
  typedef struct packed {
    logic clear;   // start a new search
    logic sample;  // an entry's stamp and frame are on the read port
  } scan_ctrl_t;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_DECODE    = 9'b000000010,
    ST_PROBE     = 9'b000000100,
    ST_HIT       = 9'b000001000,
    ST_SCAN      = 9'b000010000,
    ST_SCAN_LAST = 9'b000100000,
    ST_PICK      = 9'b001000000,
    ST_WRITE     = 9'b010000000,
    ST_DONE      = 9'b100000000
  } seq_state_t;

endpackage

// ===== hdl/ptlru_entry_ram.sv =====
// Page table entry memory: one write port and one registered read port.
`timescale 1ns / 1ps

module ptlru_entry_ram #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 69
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ptlru_lru_scan.sv =====
// Age compare unit: tracks the oldest valid entry seen during a table sweep.
`timescale 1ns / 1ps

module ptlru_lru_scan
  import ptlru_pkg::*;
#(
  parameter int IDX_W   = 6,
  parameter int FRAME_W = 5,
  parameter int STAMP_W = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  scan_ctrl_t         ctrl,
  input  logic [IDX_W-1:0]   idx,
  input  logic [STAMP_W-1:0] stamp,
  input  logic [FRAME_W-1:0] frame,
  output logic               found,
  output logic [IDX_W-1:0]   victim,
  output logic [FRAME_W-1:0] victim_frame
);

  logic [STAMP_W-1:0] oldest;
  logic               take;

  // Strictly older wins, so on a tie the earlier (lower) page stays.
  assign take = ctrl.sample && (!found || (stamp < oldest));

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      oldest       <= stamp;
      victim       <= idx;
      victim_frame <= frame;
    end
  end

endmodule

// ===== hdl/paged_translation_with_lru_eviction_top.sv =====
// Top level of the paged address translation block with LRU eviction.
`timescale 1ns / 1ps

// Usage
// An access enters on the s_ stream as one transaction: process id and
// virtual address. The block looks the page up in that process's page table
// and returns one result transaction on the m_ stream with status, fault flag,
// virtual page, physical page and physical address. s_tready is high only
// while the sequencer is idle, so one access is handled at a time.
// After the accepting edge the access passes through decode and probe. A hit
// then goes through the hit and write states, a miss served from the free
// frame pool straight to write, and a bad process id from decode to done.
// The block is ready again at the edge that raises m_tvalid. A miss with no
// free frame sweeps the process's MAX_VPAGES table entries through the entry
// memory read port and the shared age comparator, one entry a cycle, then
// picks the victim and writes the new entry, or ends with no victim if none.
// The result sits in an output register. If the receiver stalls, the block
// still accepts and works on the next access, and holds that result in the
// sequencer until the output register is free again.
// Reset clears all valid bits at once (they are flip-flops), the free frame
// counter, the access clock and the configuration registers to their
// defaults. Configuration writes are taken at any edge with cfg_we high and
// should only be made while no access is in flight.

module paged_translation_with_lru_eviction_top
  import ptlru_pkg::*;
#(
  parameter int MAX_PROCS   = 4,
  parameter int MAX_VPAGES  = 64,
  parameter int MAX_FRAMES  = 32,
  parameter int STAMP_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [5:0]  cfg_wdata,
  // Access stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // proc_id[1:0], virt_addr[23:2]
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // status[1:0], fault[2], virt_page[8:3],
                                 // phys_page[13:9], phys_addr[34:14], zero pad
);

  localparam int ENTRY_COUNT = MAX_PROCS * MAX_VPAGES;
  localparam int ENT_W       = $clog2(ENTRY_COUNT);
  localparam int VPN_W       = $clog2(MAX_VPAGES);
  localparam int FRAME_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int NFF_W       = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W       = (NFF_W > 6) ? NFF_W : 6;
  localparam int WORD_W      = STAMP_WIDTH + FRAME_W;

  // Configuration registers.
  logic [4:0] offset_bits;
  logic [2:0] vpn_bits;
  logic [5:0] phys_page_count;
  logic [2:0] process_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits     <= 5'd12;
      vpn_bits        <= 3'd6;
      phys_page_count <= 6'd32;
      process_count   <= 3'd4;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_OFFSET_BITS: offset_bits     <= cfg_wdata[4:0];
        REG_VPN_BITS:    vpn_bits        <= cfg_wdata[2:0];
        REG_FRAME_COUNT: phys_page_count <= cfg_wdata;
        REG_PROC_COUNT:  process_count   <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  seq_state_t state, state_next;

  // Access being worked on.
  logic [1:0]         pid;
  logic [21:0]        addr;
  logic [5:0]         vpage;
  logic [15:0]        offset;
  logic [ENT_W-1:0]   base;
  logic [ENT_W-1:0]   idx;
  logic               miss;
  logic [FRAME_W-1:0] frame;

  // Table state outside the entry memory.
  logic [ENTRY_COUNT-1:0] valid;
  logic [NFF_W-1:0]       next_free;
  logic [STAMP_WIDTH-1:0] access_clock;

  // Sweep control.
  logic [VPN_W-1:0] scan_i;
  logic [VPN_W-1:0] cmp_i;
  logic             cmp_v;

  // Pending result, waiting for the output register.
  logic [1:0]  res_status;
  logic        res_fault;
  logic [5:0]  res_vpage;
  logic [4:0]  res_ppage;
  logic [20:0] res_paddr;

  // Decode of the captured address.
  logic [4:0]       ob;
  logic [2:0]       vb;
  logic [21:0]      addr_sh;
  logic [5:0]       vpn_raw;
  logic [15:0]      off_mask;
  logic [VPN_W-1:0] vpn_wrap [64];
  logic             bad_dec;
  logic             has_free;

  for (genvar g = 0; g < 64; g++) begin : g_wrap
    assign vpn_wrap[g] = VPN_W'(g % MAX_VPAGES);
  end

  assign ob       = (offset_bits > 5'd16) ? 5'd16 : offset_bits;
  assign vb       = (vpn_bits > 3'd6) ? 3'd6 : vpn_bits;
  assign addr_sh  = addr >> ob;
  assign vpn_raw  = addr_sh[5:0] & ~(6'h3f << vb);
  assign off_mask = ~(16'hffff << ob);
  assign bad_dec  = ({3'b000, pid} >= {2'b00, process_count})
                 || ({3'b000, pid} >= 5'(MAX_PROCS));
  assign has_free = (CMP_W'(next_free) < CMP_W'(phys_page_count))
                 && (CMP_W'(next_free) < CMP_W'(MAX_FRAMES));

  // Entry memory and the age comparator.
  logic              ram_we;
  logic [ENT_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic              found;
  logic [VPN_W-1:0]  victim;
  logic [FRAME_W-1:0] victim_frame;
  scan_ctrl_t        scan_ctrl;

  assign ram_we    = (state == ST_WRITE);
  assign ram_raddr = (state == ST_PROBE) ? idx : (base + ENT_W'(scan_i));

  ptlru_entry_ram #(
    .DEPTH (ENTRY_COUNT),
    .ADDR_W(ENT_W),
    .DATA_W(WORD_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx),
    .wdata({access_clock, frame}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign scan_ctrl.clear  = (state == ST_PROBE);
  assign scan_ctrl.sample = cmp_v;

  ptlru_lru_scan #(
    .IDX_W  (VPN_W),
    .FRAME_W(FRAME_W),
    .STAMP_W(STAMP_WIDTH)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (scan_ctrl),
    .idx         (cmp_i),
    .stamp       (ram_rdata[WORD_W-1:FRAME_W]),
    .frame       (ram_rdata[FRAME_W-1:0]),
    .found       (found),
    .victim      (victim),
    .victim_frame(victim_frame)
  );

  assign s_tready = (state == ST_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (s_tvalid) state_next = ST_DECODE;
      ST_DECODE:    state_next = bad_dec ? ST_DONE : ST_PROBE;
      ST_PROBE: begin
        priority if (valid[idx]) state_next = ST_HIT;
        else if (has_free)       state_next = ST_WRITE;
        else                     state_next = ST_SCAN;
      end
      ST_HIT:       state_next = ST_WRITE;
      ST_SCAN:      if (scan_i == VPN_W'(MAX_VPAGES - 1)) state_next = ST_SCAN_LAST;
      ST_SCAN_LAST: state_next = ST_PICK;
      ST_PICK:      state_next = found ? ST_WRITE : ST_DONE;
      ST_WRITE:     state_next = ST_DONE;
      ST_DONE:      if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Table control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      next_free    <= '0;
      access_clock <= '0;
      cmp_v        <= 1'b0;
    end else begin
      cmp_v <= (state == ST_SCAN) && valid[base + ENT_W'(scan_i)];
      if ((state == ST_PROBE) && !valid[idx] && has_free) begin
        next_free <= next_free + NFF_W'(1);
      end
      if ((state == ST_PICK) && found) begin
        valid[base + ENT_W'(victim)] <= 1'b0;
      end
      if (state == ST_WRITE) begin
        if (miss) begin
          valid[idx] <= 1'b1;
        end
        access_clock <= access_clock + STAMP_WIDTH'(1);
      end
    end
  end

  // Datapath registers of the access in flight.
  always_ff @(posedge clk) begin
    cmp_i <= scan_i;
    unique case (state)
      ST_IDLE: begin
        pid  <= s_tdata[1:0];
        addr <= s_tdata[23:2];
      end
      ST_DECODE: begin
        vpage  <= 6'(vpn_wrap[vpn_raw]);
        offset <= addr[15:0] & off_mask;
        base   <= ENT_W'(pid) * ENT_W'(MAX_VPAGES);
        idx    <= ENT_W'(pid) * ENT_W'(MAX_VPAGES) + ENT_W'(vpn_wrap[vpn_raw]);
        if (bad_dec) begin
          res_status <= STATUS_BAD_PROC;
          res_fault  <= 1'b0;
          res_vpage  <= '0;
          res_ppage  <= '0;
          res_paddr  <= '0;
        end
      end
      ST_PROBE: begin
        miss   <= !valid[idx];
        scan_i <= '0;
        frame  <= FRAME_W'(next_free);
      end
      ST_HIT: begin
        frame <= ram_rdata[FRAME_W-1:0];
      end
      ST_SCAN: begin
        scan_i <= scan_i + VPN_W'(1);
      end
      ST_SCAN_LAST: ;
      ST_PICK: begin
        frame <= victim_frame;
        if (!found) begin
          res_status <= STATUS_NO_VICTIM;
          res_fault  <= 1'b1;
          res_vpage  <= vpage;
          res_ppage  <= '0;
          res_paddr  <= '0;
        end
      end
      ST_WRITE: begin
        res_status <= STATUS_OK;
        res_fault  <= miss;
        res_vpage  <= vpage;
        res_ppage  <= 5'(frame);
        res_paddr  <= (21'(frame) << ob) | 21'(offset);
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // Output register; freed when the receiver takes the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
      m_tdata <= {5'b00000, res_paddr, res_ppage, res_vpage, res_fault, res_status};
    end
  end

endmodule

// ===== verif/paged_translation_with_lru_eviction_top_test.sv =====
// Self-checking testbench for the paged address translation block with LRU eviction.
`timescale 1ns / 1ps

module paged_translation_with_lru_eviction_top_test;
  import ptlru_pkg::*;

  localparam int VPAGES       = 64;
  localparam int PROCS        = 4;
  localparam int IDLE_LIMIT   = 5000;  // cycles with no transaction before giving up
  localparam int SETTLE_TICKS = 80;    // longer than the slowest access

  // One translation result, packed as on m_tdata[34:0].
  typedef struct packed {
    logic [20:0] paddr;
    logic [4:0]  ppage;
    logic [5:0]  vpage;
    logic        fault;
    logic [1:0]  status;
  } xlate_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [5:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // proc_id[1:0], virt_addr[23:2]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // status[1:0], fault[2], virt_page[8:3],
                               // phys_page[13:9], phys_addr[34:14], zero pad

  paged_translation_with_lru_eviction_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a private copy of the page tables and the registers.
  logic        tbl_valid [PROCS*VPAGES];
  logic [4:0]  tbl_frame [PROCS*VPAGES];
  logic [63:0] tbl_stamp [PROCS*VPAGES];
  logic [5:0]  free_next;
  logic [63:0] access_count;
  logic [4:0]  cfg_offset_bits;
  logic [2:0]  cfg_vpn_bits;
  logic [5:0]  cfg_frame_count;
  logic [2:0]  cfg_proc_count;

  xlate_result_t pending_results[$];
  int            mismatch_count = 0;

  // Receiver control: random stalls, or one long hold-off on request.
  bit sink_idle_on = 1'b1;
  bit src_idle_on  = 1'b1;
  bit sink_hold_req = 1'b0;
  int sink_hold_len = 0;

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    mismatch_count++;
    $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic int eff_offset_bits();
    return (cfg_offset_bits > 16) ? 16 : int'(cfg_offset_bits);
  endfunction

  function automatic int eff_vpn_bits();
    return (cfg_vpn_bits > 6) ? 6 : int'(cfg_vpn_bits);
  endfunction

  function automatic int eff_proc_count();
    return (cfg_proc_count > PROCS) ? PROCS : int'(cfg_proc_count);
  endfunction

  // Works out the result of one access and updates the page tables the way
  // the block is meant to.
  function automatic xlate_result_t predict_translation(input logic [1:0] pid,
                                                        input logic [21:0] addr);
    int obe, vbe, frames, offset, vpn, base, victim;
    logic hit, found;
    logic [63:0] oldest;
    logic [4:0] frm;
    logic [31:0] wide_addr;
    xlate_result_t r;
    r = '0;
    obe = eff_offset_bits();
    vbe = eff_vpn_bits();
    frames = (cfg_frame_count > 32) ? 32 : int'(cfg_frame_count);
    if (int'(pid) >= eff_proc_count()) begin
      r.status = STATUS_BAD_PROC;
      return r;
    end
    offset = addr & ((1 << obe) - 1);
    vpn = (addr >> obe) & ((1 << vbe) - 1);
    base = int'(pid) * VPAGES;
    hit = tbl_valid[base + vpn];
    r.vpage = vpn[5:0];
    frm = '0;
    if (hit) begin
      frm = tbl_frame[base + vpn];
    end else if (int'(free_next) < frames) begin
      frm = free_next[4:0];
      free_next = free_next + 6'd1;
    end else begin
      // Least recently used page of this process; the first one found wins ties.
      found = 1'b0;
      victim = 0;
      oldest = '0;
      for (int i = 0; i < VPAGES; i++) begin
        if (tbl_valid[base + i] && (!found || tbl_stamp[base + i] < oldest)) begin
          found = 1'b1;
          victim = i;
          oldest = tbl_stamp[base + i];
        end
      end
      if (!found) begin
        r.status = STATUS_NO_VICTIM;
        r.fault = 1'b1;
        return r;
      end
      frm = tbl_frame[base + victim];
      tbl_valid[base + victim] = 1'b0;
    end
    if (!hit) begin
      tbl_valid[base + vpn] = 1'b1;
      tbl_frame[base + vpn] = frm;
    end
    tbl_stamp[base + vpn] = access_count;
    access_count = access_count + 64'd1;
    r.status = STATUS_OK;
    r.fault = !hit;
    r.ppage = frm;
    wide_addr = (32'(frm) << obe) | 32'(offset);
    r.paddr = wide_addr[20:0];
    return r;
  endfunction

  // Monitor: checks every result transaction, predicts every accepted access
  // and tracks register writes, all on the values present at the clock edge.
  always @(posedge clk) begin
    xlate_result_t got, want;
    if (rst) begin
      foreach (tbl_valid[i]) begin
        tbl_valid[i] = 1'b0;
        tbl_frame[i] = '0;
        tbl_stamp[i] = '0;
      end
      free_next = '0;
      access_count = '0;
      cfg_offset_bits = 5'd12;
      cfg_vpn_bits = 3'd6;
      cfg_frame_count = 6'd32;
      cfg_proc_count = 3'd4;
      pending_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", m_tdata, '0);
        end else begin
          got = m_tdata[34:0];
          want = pending_results.pop_front();
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
          if (got.fault !== want.fault) report_mismatch("fault", got.fault, want.fault);
          if (got.vpage !== want.vpage) report_mismatch("virt_page", got.vpage, want.vpage);
          if (got.ppage !== want.ppage) report_mismatch("phys_page", got.ppage, want.ppage);
          if (got.paddr !== want.paddr) report_mismatch("phys_addr", got.paddr, want.paddr);
          if (m_tdata[39:35] !== 5'd0) report_mismatch("padding", m_tdata[39:35], '0);
        end
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(predict_translation(s_tdata[1:0], s_tdata[23:2]));
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_OFFSET_BITS: cfg_offset_bits = cfg_wdata[4:0];
          REG_VPN_BITS:    cfg_vpn_bits = cfg_wdata[2:0];
          REG_FRAME_COUNT: cfg_frame_count = cfg_wdata[5:0];
          REG_PROC_COUNT:  cfg_proc_count = cfg_wdata[2:0];
          default: ;
        endcase
      end
    end
  end

  // Receiver: one assignment to m_tready per edge. A hold-off request wins
  // over the random stalls and is counted out here.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        stall_left = sink_hold_len - 1;
        m_tready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 99) < 20) begin
        stall_left = pick_gap() - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no transaction of any kind happens for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Offers one access and waits for the transaction. A gap, if any, is taken
  // with tvalid low before the access is put on the bus.
  task automatic send_access(input logic [1:0] pid, input logic [21:0] addr, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata <= 24'($urandom);
      repeat (gap) @(posedge clk);
    end
    s_tdata <= {addr, pid};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic int sender_gap();
    if (src_idle_on && $urandom_range(0, 99) < 40) return pick_gap();
    return 0;
  endfunction

  // Stops offering and waits until every expected result has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [5:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all_regs(input int ob, input int vb, input int frames, input int procs);
    write_reg(REG_OFFSET_BITS, 6'(ob));
    write_reg(REG_VPN_BITS, 6'(vb));
    write_reg(REG_FRAME_COUNT, 6'(frames));
    write_reg(REG_PROC_COUNT, 6'(procs));
  endtask

  // Address with random offset and upper bits; the page number mostly comes
  // from a small working set so that hits and evictions both happen.
  function automatic logic [21:0] make_addr();
    int obe, vbe, vpn;
    logic [31:0] a;
    obe = eff_offset_bits();
    vbe = eff_vpn_bits();
    a = $urandom;
    if (vbe > 0 && $urandom_range(0, 99) < 90) begin
      vpn = ($urandom_range(0, 99) < 75) ? $urandom_range(0, 3) : $urandom_range(0, 63);
      vpn = vpn & ((1 << vbe) - 1);
      a = (a & ~(32'((1 << vbe) - 1) << obe)) | (32'(vpn) << obe);
    end
    return a[21:0];
  endfunction

  function automatic logic [1:0] make_pid();
    int procs;
    procs = eff_proc_count();
    if (procs > 0 && $urandom_range(0, 99) < 85) return 2'($urandom_range(0, procs - 1));
    return 2'($urandom_range(0, 3));
  endfunction

  // Reset settings: first misses from the pool, hits, address extremes.
  task automatic test_basic_translation();
    send_access(2'd0, 22'h000000, 0);
    send_access(2'd3, 22'h3FFFFF, 0);
    send_access(2'd3, 22'h3FFFFF, 2);
    send_access(2'd0, 22'h000ABC, 0);
    drain_results();
  endtask

  // A small pool runs dry and a process evicts its least recently used page;
  // with a zero pool, processes with no pages get no victim, the other evicts.
  task automatic test_pool_and_eviction();
    write_reg(REG_FRAME_COUNT, 6'd4);
    send_access(2'd0, 22'h001000, 0);
    send_access(2'd0, 22'h002123, 0);
    send_access(2'd1, 22'h001234, 0);
    send_access(2'd0, 22'h005FFF, 1);
    send_access(2'd0, 22'h001001, 0);
    send_access(2'd0, 22'h006000, 0);
    drain_results();
    write_reg(REG_FRAME_COUNT, 6'd0);
    send_access(2'd3, 22'h007000, 0);
    send_access(2'd2, 22'h000000, 0);
    send_access(2'd0, 22'h002000, 3);
    drain_results();
  endtask

  // Out-of-range register values and the bad process id.
  task automatic test_register_extremes();
    write_reg(REG_PROC_COUNT, 6'd0);
    send_access(2'd0, 22'h000000, 0);
    send_access(2'd3, 22'h3FFFFF, 0);
    drain_results();
    write_all_regs(31, 7, 63, 7);
    send_access(2'd3, 22'h3FFFFF, 0);
    send_access(2'd0, 22'h3FFFFF, 0);
    drain_results();
    write_all_regs(0, 0, 63, 1);
    send_access(2'd0, 22'h2AAAAA, 0);
    send_access(2'd1, 22'h000000, 0);
    drain_results();
    write_all_regs(0, 7, 32, 4);
    send_access(2'd2, 22'h155555, 0);
    send_access(2'd2, 22'h15552A, 0);
    drain_results();
  endtask

  // The receiver holds off for a long stretch while accesses keep coming,
  // so the block fills up and stops accepting; then everything drains.
  task automatic test_backpressure();
    sink_idle_on = 1'b0;
    src_idle_on = 1'b0;
    sink_hold_len = 300;
    sink_hold_req = 1'b1;
    @(posedge clk);
    repeat (12) send_access(make_pid(), make_addr(), 0);
    drain_results();
    sink_idle_on = 1'b1;
    src_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic(input int ob, input int vb, input int frames,
                                     input int procs, input int count, input bit idle);
    write_all_regs(ob, vb, frames, procs);
    sink_idle_on = idle;
    src_idle_on = idle;
    repeat (count) begin
      if ($urandom_range(0, 99) < 8) send_access(2'($urandom), 22'($urandom), sender_gap());
      else send_access(make_pid(), make_addr(), sender_gap());
    end
    drain_results();
    sink_idle_on = 1'b1;
    src_idle_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_translation();
    test_pool_and_eviction();
    test_register_extremes();
    // Small pools first, larger ones later, then a one-frame pool and random settings.
    test_random_traffic(0, 2, 4, 2, 90, 1'b1);
    test_random_traffic(16, 3, 8, 3, 90, 1'b1);
    test_random_traffic(31, 7, 0, 7, 90, 1'b0);
    test_backpressure();
    test_random_traffic(5, 0, 20, 1, 60, 1'b1);
    test_random_traffic(12, 6, 63, 4, 100, 1'b1);
    test_random_traffic(20, 4, 32, 0, 20, 1'b1);
    test_random_traffic(9, 5, 1, 4, 90, 1'b1);
    repeat (2)
      test_random_traffic($urandom_range(0, 31), $urandom_range(0, 7),
                          $urandom_range(0, 63), $urandom_range(0, 7), 60, 1'b1);
    repeat (SETTLE_TICKS) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
